### rtl/core/rmj_pkg.sv
// shared constants and transaction types of the radar measurement jacobian
package rmj_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_LANES  = 6;

  // one state vector
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] pos_x;
    logic signed [DATA_WIDTH-1:0] pos_y;
    logic signed [DATA_WIDTH-1:0] vel_x;
    logic signed [DATA_WIDTH-1:0] vel_y;
  } rmj_in_t;

  // distinct non-zero jacobian entries
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] range_dx;
    logic signed [DATA_WIDTH-1:0] range_dy;
    logic signed [DATA_WIDTH-1:0] bearing_dx;
    logic signed [DATA_WIDTH-1:0] bearing_dy;
    logic signed [DATA_WIDTH-1:0] rate_dx;
    logic signed [DATA_WIDTH-1:0] rate_dy;
    logic                         zero_position;
  } rmj_out_t;

endpackage

### rtl/core/rmj_mul_cell.sv
// one shift-add step of a bit-serial multiplier chain
module rmj_mul_cell #(
  parameter int AW = 8,
  parameter int BW = 8,
  parameter int J  = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  input  logic [AW+BW-1:0] acc_i,
  output logic [AW-1:0]    a_o,
  output logic [BW-1:0]    b_o,
  output logic [AW+BW-1:0] acc_o
);
  localparam int PW = AW + BW;

  logic [AW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [PW-1:0] acc_d, acc_q;

  // add the shifted multiplicand when the current multiplier bit is set
  always_comb begin
    acc_d = acc_i;
    if (b_i[0]) begin
      acc_d = acc_i + (PW'(a_i) << J);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_i;
      b_q   <= b_i >> 1;
      acc_q <= acc_d;
    end
  end

  assign a_o   = a_q;
  assign b_o   = b_q;
  assign acc_o = acc_q;

endmodule

### rtl/core/rmj_mul_chain.sv
// row of shift-add cells forming a pipelined unsigned multiplier
module rmj_mul_chain #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] prod_o
);
  localparam int PW = AW + BW;

  logic [AW-1:0] a_w   [BW+1];
  logic [BW-1:0] b_w   [BW+1];
  logic [PW-1:0] acc_w [BW+1];

  assign a_w[0]   = a_i;
  assign b_w[0]   = b_i;
  assign acc_w[0] = '0;

  // one cell per multiplier bit, lsb first
  for (genvar j = 0; j < BW; j++) begin : g_cell
    rmj_mul_cell #(
      .AW(AW),
      .BW(BW),
      .J (j)
    ) u_cell (
      .clk_i(clk_i),
      .en_i (en_i),
      .a_i  (a_w[j]),
      .b_i  (b_w[j]),
      .acc_i(acc_w[j]),
      .a_o  (a_w[j+1]),
      .b_o  (b_w[j+1]),
      .acc_o(acc_w[j+1])
    );
  end

  assign prod_o = acc_w[BW];

endmodule

### rtl/core/rmj_root_cell.sv
// one bit of floor(sqrt(num / den)) by restoring trial subtraction
module rmj_root_cell #(
  parameter int CW = 64,
  parameter int QW = 9,
  parameter int B  = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [CW-1:0] rem_i,
  input  logic [CW-1:0] den_i,
  input  logic [CW-1:0] part_i,
  input  logic [QW-1:0] quo_i,
  output logic [CW-1:0] rem_o,
  output logic [CW-1:0] den_o,
  output logic [CW-1:0] part_o,
  output logic [QW-1:0] quo_o
);
  logic [CW-1:0] delta;
  logic          take;
  logic [CW-1:0] rem_d, rem_q, den_q, part_d, part_q;
  logic [QW-1:0] quo_d, quo_q;

  // (q + 2^B)^2 * den - q^2 * den, with part = q * den
  assign delta = (part_i << (B + 1)) + (den_i << (2 * B));
  assign take  = (rem_i >= delta);

  always_comb begin
    rem_d    = rem_i;
    part_d   = part_i;
    quo_d    = quo_i;
    quo_d[B] = take;
    if (take) begin
      rem_d  = rem_i - delta;
      part_d = part_i + (den_i << B);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      part_q <= part_d;
      quo_q  <= quo_d;
    end
  end

  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign part_o = part_q;
  assign quo_o  = quo_q;

endmodule

### rtl/core/radar_measurement_jacobian.sv
// radar measurement jacobian top level: multiplier chains and root cell rows
// throughput: one transaction per cycle while the skid register is empty, set by the
// shift-add and root cell rows
// a result held by out_stall_i moves to a skid register; the pipe stops only when both are full
// reset clears all valid bits asynchronously; datapath registers are not reset
module radar_measurement_jacobian (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rmj_pkg::rmj_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rmj_pkg::rmj_out_t out_data_o
);
  import rmj_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int CW = 8 * W + 4 * F;
  localparam int QW = W + 1;
  localparam int L  = 7 * W + 3;
  localparam logic [QW-1:0] CAP_POS = {2'b00, {(W-1){1'b1}}};
  localparam logic [QW-1:0] CAP_NEG = {2'b01, {(W-1){1'b0}}};

  typedef struct packed {
    logic         zero;
    logic         sx;
    logic         sy;
    logic         sa;
    logic         sb;
    logic [W-1:0] mx;
    logic [W-1:0] my;
  } side1_t;

  typedef struct packed {
    logic           zero;
    logic           sx;
    logic           sy;
    logic           sc;
    logic [2*W-1:0] x2;
    logic [2*W-1:0] y2;
    logic [2*W-1:0] s;
  } side3_t;

  typedef struct packed {
    logic           zero;
    logic           sx;
    logic           sy;
    logic           sc;
    logic [2*W-1:0] x2;
    logic [2*W-1:0] y2;
    logic [2*W-1:0] s;
    logic [4*W-1:0] ss;
  } side4_t;

  typedef struct packed {
    logic                 zero;
    logic [NUM_LANES-1:0] neg;
  } side5_t;

  logic     en;
  logic     skid_vld_q, skid_vld_d, out_vld_q, out_vld_d;
  rmj_out_t out_q, out_d, skid_q, skid_d, res_d;
  logic [L-1:0] vld_q;

  assign en = !skid_vld_q;

  // valid bits ride alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  // input stage: sign and magnitude split
  logic [W-1:0] px_mag, py_mag, vx_mag, vy_mag;
  logic [W-1:0] mx_q, my_q, mvx_q, mvy_q;
  side1_t       s0_q;

  assign px_mag = in_data_i.pos_x[W-1] ? W'(-in_data_i.pos_x) : W'(in_data_i.pos_x);
  assign py_mag = in_data_i.pos_y[W-1] ? W'(-in_data_i.pos_y) : W'(in_data_i.pos_y);
  assign vx_mag = in_data_i.vel_x[W-1] ? W'(-in_data_i.vel_x) : W'(in_data_i.vel_x);
  assign vy_mag = in_data_i.vel_y[W-1] ? W'(-in_data_i.vel_y) : W'(in_data_i.vel_y);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q    <= px_mag;
      my_q    <= py_mag;
      mvx_q   <= vx_mag;
      mvy_q   <= vy_mag;
      s0_q.zero <= (px_mag == '0) && (py_mag == '0);
      s0_q.sx <= in_data_i.pos_x[W-1];
      s0_q.sy <= in_data_i.pos_y[W-1];
      s0_q.sa <= in_data_i.vel_x[W-1] ^ in_data_i.pos_y[W-1];
      s0_q.sb <= !(in_data_i.vel_y[W-1] ^ in_data_i.pos_x[W-1]);
      s0_q.mx <= px_mag;
      s0_q.my <= py_mag;
    end
  end

  // first products: px^2, py^2, vx*py, vy*px
  logic [2*W-1:0] x2_p, y2_p, a_p, b_p;

  rmj_mul_chain #(.AW(W), .BW(W)) u_mul_x2 (
    .clk_i(clk_i), .en_i(en), .a_i(mx_q), .b_i(mx_q), .prod_o(x2_p)
  );
  rmj_mul_chain #(.AW(W), .BW(W)) u_mul_y2 (
    .clk_i(clk_i), .en_i(en), .a_i(my_q), .b_i(my_q), .prod_o(y2_p)
  );
  rmj_mul_chain #(.AW(W), .BW(W)) u_mul_a (
    .clk_i(clk_i), .en_i(en), .a_i(mvx_q), .b_i(my_q), .prod_o(a_p)
  );
  rmj_mul_chain #(.AW(W), .BW(W)) u_mul_b (
    .clk_i(clk_i), .en_i(en), .a_i(mvy_q), .b_i(mx_q), .prod_o(b_p)
  );

  side1_t side1_q [W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q[0] <= s0_q;
      for (int k = 1; k < W; k++) begin
        side1_q[k] <= side1_q[k-1];
      end
    end
  end

  // squared range and cross term in sign-magnitude form
  side1_t         s1;
  logic [2*W-1:0] c_d;
  logic           sc_d;
  side3_t         ph2_q;
  logic [2*W-1:0] c2_q;
  logic [W-1:0]   mx2_q, my2_q;

  assign s1 = side1_q[W-1];

  always_comb begin
    if (s1.sa == s1.sb) begin
      c_d  = a_p + b_p;
      sc_d = s1.sa;
    end else if (a_p >= b_p) begin
      c_d  = a_p - b_p;
      sc_d = s1.sa;
    end else begin
      c_d  = b_p - a_p;
      sc_d = s1.sb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph2_q.zero <= s1.zero;
      ph2_q.sx   <= s1.sx;
      ph2_q.sy   <= s1.sy;
      ph2_q.sc   <= sc_d;
      ph2_q.x2   <= x2_p;
      ph2_q.y2   <= y2_p;
      ph2_q.s    <= x2_p + y2_p;
      c2_q       <= c_d;
      mx2_q      <= s1.mx;
      my2_q      <= s1.my;
    end
  end

  // second products: py*c, px*c, s^2
  logic [4*W-1:0] yc_p, xc_p, ss_p;

  rmj_mul_chain #(.AW(2*W), .BW(2*W)) u_mul_yc (
    .clk_i(clk_i), .en_i(en), .a_i(c2_q), .b_i((2*W)'(my2_q)), .prod_o(yc_p)
  );
  rmj_mul_chain #(.AW(2*W), .BW(2*W)) u_mul_xc (
    .clk_i(clk_i), .en_i(en), .a_i(c2_q), .b_i((2*W)'(mx2_q)), .prod_o(xc_p)
  );
  rmj_mul_chain #(.AW(2*W), .BW(2*W)) u_mul_ss (
    .clk_i(clk_i), .en_i(en), .a_i(ph2_q.s), .b_i(ph2_q.s), .prod_o(ss_p)
  );

  side3_t side3_q [2*W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q[0] <= ph2_q;
      for (int k = 1; k < 2 * W; k++) begin
        side3_q[k] <= side3_q[k-1];
      end
    end
  end

  // third products: (py*c)^2, (px*c)^2, s^3
  side3_t         s3;
  side4_t         s4_in;
  logic [6*W-1:0] yc2_p, xc2_p;
  logic [7*W-1:0] s3_p;

  assign s3 = side3_q[2*W-1];

  rmj_mul_chain #(.AW(3*W), .BW(3*W)) u_mul_yc2 (
    .clk_i(clk_i), .en_i(en), .a_i(yc_p[3*W-1:0]), .b_i(yc_p[3*W-1:0]), .prod_o(yc2_p)
  );
  rmj_mul_chain #(.AW(3*W), .BW(3*W)) u_mul_xc2 (
    .clk_i(clk_i), .en_i(en), .a_i(xc_p[3*W-1:0]), .b_i(xc_p[3*W-1:0]), .prod_o(xc2_p)
  );
  rmj_mul_chain #(.AW(4*W), .BW(3*W)) u_mul_s3 (
    .clk_i(clk_i), .en_i(en), .a_i(ss_p), .b_i((3*W)'(s3.s)), .prod_o(s3_p)
  );

  always_comb begin
    s4_in.zero = s3.zero;
    s4_in.sx   = s3.sx;
    s4_in.sy   = s3.sy;
    s4_in.sc   = s3.sc;
    s4_in.x2   = s3.x2;
    s4_in.y2   = s3.y2;
    s4_in.s    = s3.s;
    s4_in.ss   = ss_p;
  end

  side4_t side4_q [3*W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q[0] <= s4_in;
      for (int k = 1; k < 3 * W; k++) begin
        side4_q[k] <= side4_q[k-1];
      end
    end
  end

  // numerators and denominators of the six root-of-quotient lanes
  side4_t        s4;
  side5_t        s5_in;
  logic [CW-1:0] n_init [NUM_LANES];
  logic [CW-1:0] d_init [NUM_LANES];

  assign s4 = side4_q[3*W-1];

  always_comb begin
    n_init[0] = CW'(s4.x2) << (2 * F);
    d_init[0] = CW'(s4.s);
    n_init[1] = CW'(s4.y2) << (2 * F);
    d_init[1] = CW'(s4.s);
    n_init[2] = CW'(s4.y2) << (4 * F);
    d_init[2] = CW'(s4.ss);
    n_init[3] = CW'(s4.x2) << (4 * F);
    d_init[3] = CW'(s4.ss);
    n_init[4] = CW'(yc2_p) << (2 * F);
    d_init[4] = CW'(s3_p[6*W-1:0]);
    n_init[5] = CW'(xc2_p) << (2 * F);
    d_init[5] = CW'(s3_p[6*W-1:0]);
    s5_in.zero   = s4.zero;
    s5_in.neg[0] = s4.sx;
    s5_in.neg[1] = s4.sy;
    s5_in.neg[2] = !s4.sy;
    s5_in.neg[3] = s4.sx;
    s5_in.neg[4] = s4.sy ^ s4.sc;
    s5_in.neg[5] = s4.sx ^ !s4.sc;
  end

  side5_t side5_q [W+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side5_q[0] <= s5_in;
      for (int k = 1; k <= W; k++) begin
        side5_q[k] <= side5_q[k-1];
      end
    end
  end

  // root cell rows, one result bit per cell, msb first
  logic [CW-1:0] rem_w  [NUM_LANES][W+2];
  logic [CW-1:0] den_w  [NUM_LANES][W+2];
  logic [CW-1:0] part_w [NUM_LANES][W+2];
  logic [QW-1:0] quo_w  [NUM_LANES][W+2];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    assign rem_w[l][0]  = n_init[l];
    assign den_w[l][0]  = d_init[l];
    assign part_w[l][0] = '0;
    assign quo_w[l][0]  = '0;
    for (genvar k = 0; k <= W; k++) begin : g_bit
      rmj_root_cell #(
        .CW(CW),
        .QW(QW),
        .B (W - k)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .rem_i (rem_w[l][k]),
        .den_i (den_w[l][k]),
        .part_i(part_w[l][k]),
        .quo_i (quo_w[l][k]),
        .rem_o (rem_w[l][k+1]),
        .den_o (den_w[l][k+1]),
        .part_o(part_w[l][k+1]),
        .quo_o (quo_w[l][k+1])
      );
    end
  end

  // saturate and restore sign
  side5_t        s5;
  logic [W-1:0]  res_v [NUM_LANES];

  assign s5 = side5_q[W];

  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    for (int l = 0; l < NUM_LANES; l++) begin
      lim = s5.neg[l] ? CAP_NEG : CAP_POS;
      mag = (quo_w[l][W+1] > lim) ? lim : quo_w[l][W+1];
      res_v[l] = s5.neg[l] ? W'(-mag[W-1:0]) : mag[W-1:0];
    end
  end

  always_comb begin
    res_d.range_dx      = s5.zero ? '0 : res_v[0];
    res_d.range_dy      = s5.zero ? '0 : res_v[1];
    res_d.bearing_dx    = s5.zero ? '0 : res_v[2];
    res_d.bearing_dy    = s5.zero ? '0 : res_v[3];
    res_d.rate_dx       = s5.zero ? '0 : res_v[4];
    res_d.rate_dy       = s5.zero ? '0 : res_v[5];
    res_d.zero_position = s5.zero;
  end

  // output register with skid stage
  logic out_take;

  assign out_take = out_vld_q && !out_stall_i;

  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      if (out_take) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (vld_q[L-1]) begin
      if (!out_vld_q || out_take) begin
        out_d     = res_d;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res_d;
        skid_vld_d = 1'b1;
      end
    end else if (out_take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  localparam logic signed [W-1:0] ONE_Q = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};

  // skid holds data only behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while output empty");

  // skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
    else $error("skid filled without a stalled output");

  // zero position gives an all-zero jacobian
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.zero_position) |->
      (out_q.range_dx == '0 && out_q.range_dy == '0 && out_q.bearing_dx == '0 &&
       out_q.bearing_dy == '0 && out_q.rate_dx == '0 && out_q.rate_dy == '0))
    else $error("non-zero jacobian for zero position");

  // range entries are direction cosines
  a_range_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.range_dx <= ONE_Q && out_q.range_dx >= -ONE_Q &&
                   out_q.range_dy <= ONE_Q && out_q.range_dy >= -ONE_Q))
    else $error("range derivative beyond unit magnitude");
`endif

endmodule
